// ----- sv/wdwa_pkg.sv -----
package wdwa_pkg;

  localparam int NUM_BINS     = 4096;
  localparam int MAX_FRAGMENT = 1024;
  localparam int BIN_W        = $clog2(NUM_BINS);
  localparam int FRAG_W       = $clog2(MAX_FRAGMENT);

  localparam int MODE_W  = 3;
  localparam int INDEX_W = 12;
  localparam int POS_W   = 28;
  localparam int VAL_W   = 32;
  localparam int WGT_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_COORD  = 3'd0,
    MODE_WR_WEIGHT = 3'd1,
    MODE_WR_COUP   = 3'd2,
    MODE_ADD_SITE  = 3'd3,
    MODE_RD_COUP   = 3'd4
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_SIZE  = 2'd0,
    CFG_FLANK     = 2'd1,
    CFG_FRAG_LEN  = 2'd2,
    CFG_BINS_USED = 2'd3
  } cfg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture input transaction
    logic div_start;
    logic div_step;
    logic win_setup;  // compute window bounds from quotient
    logic rd_issue;   // read coord/coupling for bin k
    logic wt_issue;   // distance calc + weight read
    logic wb;         // write back coupling of bin k
    logic k_inc;
    logic simple_op;  // perform table write / coupling read
    logic rd_capture; // capture read-out coupling
    logic clr_step;
    logic out_load;
  } wdwa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic win_empty;
    logic k_last;
    logic clr_done;
    logic is_add;
    logic is_read;
  } wdwa_stat_t;

endpackage

// ----- sv/wdwa_if.sv -----
interface wdwa_in_if;
  import wdwa_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [INDEX_W-1:0] index;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   value;
  modport source (output valid, mode, index, position, value, input ready);
  modport sink   (input valid, mode, index, position, value, output ready);
endinterface

interface wdwa_out_if;
  import wdwa_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] coupling_value;
  logic             saturated;
  modport source (output valid, coupling_value, saturated, input ready);
  modport sink   (input valid, coupling_value, saturated, output ready);
endinterface

// ----- sv/wdwa_ctrl.sv -----
module wdwa_ctrl import wdwa_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  wdwa_stat_t stat,
  output wdwa_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_DIV   = 10'b0000000100,
    S_WIN   = 10'b0000001000,
    S_RD    = 10'b0000010000,
    S_WT    = 10'b0000100000,
    S_ACC   = 10'b0001000000,
    S_WB    = 10'b0010000000,
    S_SIMPLE= 10'b0100000000,
    S_RDOUT = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign out_valid = out_valid_r;
  // output register frees once the old result is taken
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = S_SIMPLE;
        end
      end
      S_SIMPLE: begin
        if (stat.is_add) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else if (stat.is_read) begin
          cmd.simple_op = 1'b1;
          state_nxt     = S_RDOUT;
        end else begin
          cmd.simple_op = 1'b1;
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RDOUT: begin
        cmd.rd_capture = 1'b1;
        cmd.out_load   = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_nxt = S_WIN;
      end
      S_WIN: begin
        cmd.win_setup = 1'b1;
        state_nxt     = S_RD;
      end
      S_RD: begin
        if (stat.win_empty) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_WT;
        end
      end
      S_WT: begin
        cmd.wt_issue = 1'b1;
        state_nxt    = S_ACC;
      end
      S_ACC: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        if (stat.k_last) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- sv/wdwa_dp.sv -----
module wdwa_dp import wdwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [INDEX_W-1:0]    in_index,
  input  logic [POS_W-1:0]      in_position,
  input  logic [VAL_W-1:0]      in_value,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  wdwa_cmd_t             cmd,
  output wdwa_stat_t            stat,
  output logic [VAL_W-1:0]      out_coupling_value,
  output logic                  out_saturated
);

  localparam int LIM_W = BIN_W + 1;

  logic [15:0]  bin_size_r;
  logic [7:0]   flank_r;
  logic [10:0]  frag_len_r;
  logic [12:0]  bins_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_size_r  <= 16'd50;
      flank_r     <= 8'd10;
      frag_len_r  <= 11'd700;
      bins_used_r <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BIN_SIZE:  bin_size_r  <= cfg_data;
        CFG_FLANK:     flank_r     <= cfg_data[7:0];
        CFG_FRAG_LEN:  frag_len_r  <= cfg_data[10:0];
        CFG_BINS_USED: bins_used_r <= cfg_data[12:0];
      endcase
    end
  end

  // captured transaction
  logic [MODE_W-1:0]  mode_r;
  logic [INDEX_W-1:0] idx_r;
  logic [POS_W-1:0]   pos_r;
  logic [VAL_W-1:0]   val_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      idx_r  <= in_index;
      pos_r  <= in_position;
      val_r  <= in_value;
    end
  end

  assign stat.is_add  = (mode_r == MODE_ADD_SITE);
  assign stat.is_read = (mode_r == MODE_RD_COUP);

  // restoring divider, one quotient bit per cycle
  logic [POS_W-1:0]         quo_r;
  logic [16:0]              rem_r;
  logic [$clog2(POS_W)-1:0] dcnt_r;
  logic [15:0]              divisor;
  logic [16:0]              rem_sh;
  logic [16:0]              rem_sub;

  assign divisor = (bin_size_r == 16'd0) ? 16'd1 : bin_size_r;
  assign rem_sh  = {rem_r[15:0], quo_r[POS_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign stat.div_done = (dcnt_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo_r  <= pos_r;
      rem_r  <= '0;
      dcnt_r <= $clog2(POS_W)'(POS_W - 1);
    end else if (cmd.div_step) begin
      if (!rem_sub[16]) begin
        rem_r <= rem_sub;
        quo_r <= {quo_r[POS_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[POS_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // window bounds
  logic [LIM_W-1:0] lim;
  logic [10:0]      frag;
  logic [POS_W:0]   w1, s_raw, e_raw;
  logic [LIM_W-1:0] k_r, e_r;
  logic             empty_r;

  assign lim  = (bins_used_r > 13'(NUM_BINS)) ? LIM_W'(NUM_BINS) : bins_used_r[LIM_W-1:0];
  assign frag = (frag_len_r > 11'(MAX_FRAGMENT)) ? 11'(MAX_FRAGMENT) : frag_len_r;
  assign w1    = {{(POS_W-7){1'b0}}, flank_r} + 1'b1;
  assign s_raw = ({1'b0, quo_r} > w1) ? ({1'b0, quo_r} - (w1 - 1'b1)) : (POS_W+1)'(1);
  assign e_raw = {1'b0, quo_r} + w1;

  always_ff @(posedge clk) begin
    if (cmd.win_setup) begin
      empty_r <= (lim == '0);
      if (s_raw > (POS_W+1)'(lim)) k_r <= lim - 1'b1;
      else                         k_r <= s_raw[LIM_W-1:0] - 1'b1;
      if (e_raw > (POS_W+1)'(lim)) e_r <= lim;
      else                         e_r <= e_raw[LIM_W-1:0];
    end else if (cmd.k_inc) begin
      k_r <= k_r + 1'b1;
    end
  end

  assign stat.win_empty = empty_r;
  assign stat.k_last    = (k_r + 1'b1 >= e_r);

  // memories
  logic [POS_W-1:0] coord_mem [NUM_BINS];
  logic [WGT_W-1:0] wgt_mem   [MAX_FRAGMENT];
  logic [VAL_W-1:0] coup_mem  [NUM_BINS];
  logic [POS_W-1:0] coord_q;
  logic [VAL_W-1:0] coup_q;
  logic [WGT_W-1:0] wgt_q;

  // clearing pass
  logic [LIM_W-1:0] clr_r;
  assign stat.clr_done = (clr_r == LIM_W'(NUM_BINS - 1));
  always_ff @(posedge clk) begin
    if (!rst_n)             clr_r <= '0;
    else if (cmd.clr_step)  clr_r <= clr_r + 1'b1;
  end

  logic             coup_we;
  logic [BIN_W-1:0] coup_wa;
  logic [VAL_W-1:0] coup_wd;
  logic [BIN_W-1:0] coup_ra;
  logic [VAL_W:0]   sum;
  logic [VAL_W-1:0] sum_sat;
  logic             sat_now;
  logic             hit_r;
  logic             sat_r;

  assign sum     = {1'b0, coup_q} + {{(VAL_W-WGT_W+1){1'b0}}, wgt_q};
  assign sat_now = hit_r && sum[VAL_W];
  assign sum_sat = sum[VAL_W] ? '1 : sum[VAL_W-1:0];

  always_comb begin
    coup_we = 1'b0;
    coup_wa = idx_r[BIN_W-1:0];
    coup_wd = val_r;
    if (cmd.clr_step) begin
      coup_we = 1'b1;
      coup_wa = clr_r[BIN_W-1:0];
      coup_wd = '0;
    end else if (cmd.wb) begin
      coup_we = hit_r;
      coup_wa = k_r[BIN_W-1:0];
      coup_wd = sum_sat;
    end else if (cmd.simple_op && mode_r == MODE_WR_COUP) begin
      coup_we = 1'b1;
    end
  end

  assign coup_ra = cmd.rd_issue ? k_r[BIN_W-1:0] : idx_r[BIN_W-1:0];

  // read data is held from the read through write back of the bin
  always_ff @(posedge clk) begin
    if (coup_we) coup_mem[coup_wa] <= coup_wd;
    if (cmd.rd_issue || cmd.simple_op) coup_q <= coup_mem[coup_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.simple_op && mode_r == MODE_WR_COORD) coord_mem[idx_r] <= pos_r;
    coord_q <= coord_mem[k_r[BIN_W-1:0]];
  end

  // distance and weight lookup
  logic [POS_W-1:0] site_gap;
  assign site_gap = (coord_q >= pos_r) ? coord_q - pos_r : pos_r - coord_q;

  always_ff @(posedge clk) begin
    if (cmd.simple_op && mode_r == MODE_WR_WEIGHT && idx_r < INDEX_W'(MAX_FRAGMENT))
      wgt_mem[idx_r[FRAG_W-1:0]] <= val_r[WGT_W-1:0];
    wgt_q <= wgt_mem[site_gap[FRAG_W-1:0]];
    if (cmd.wt_issue) hit_r <= (site_gap < {{(POS_W-11){1'b0}}, frag});
  end

  always_ff @(posedge clk) begin
    if (cmd.load)    sat_r <= 1'b0;
    else if (cmd.wb) sat_r <= sat_r | sat_now;
  end

  // result register
  logic [VAL_W-1:0] res_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_capture) res_r <= coup_q;
    else if (cmd.load)  res_r <= '0;
  end

  logic [VAL_W-1:0] ocv_r;
  logic             osat_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ocv_r  <= cmd.rd_capture ? coup_q : res_r;
      osat_r <= cmd.wb ? (sat_r | sat_now) : sat_r;
    end
  end

  assign out_coupling_value = ocv_r;
  assign out_saturated      = osat_r;

endmodule

// ----- sv/windowed_distance_weight_accumulator.sv -----
// Windowed distance-weight accumulator. One transaction is taken at a time.
// Table writes and coupling reads pass through a simple-operation state (reads
// also a read-out state) before the next acceptance; an add-site transaction runs
// a 28-step bin division and window setup, then for each visited bin a read,
// weight lookup, sum and write back. A result that is not taken holds off the
// next transaction. After reset a clearing pass zeroes all 4096 coupling memory
// entries, during which no transaction is accepted; configuration is
// meant to be written only while no transaction is in flight.
module windowed_distance_weight_accumulator import wdwa_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  wdwa_in_if.sink               in_ch,
  wdwa_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  wdwa_cmd_t  cmd;
  wdwa_stat_t stat;

  wdwa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wdwa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_ch.mode),
    .in_index           (in_ch.index),
    .in_position        (in_ch.position),
    .in_value           (in_ch.value),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cmd                (cmd),
    .stat               (stat),
    .out_coupling_value (out_ch.coupling_value),
    .out_saturated      (out_ch.saturated)
  );

endmodule

// ----- sv/wdwa_checker.sv -----
module wdwa_checker import wdwa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [VAL_W-1:0] out_coupling_value
);

  // sequential: no new transaction right after acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted back to back");

  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !$rose(out_valid)) else $error("result too early");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_coupling_value))
    else $error("result dropped");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready) else $error("bad reset");

endmodule

bind windowed_distance_weight_accumulator wdwa_checker u_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_coupling_value (out_ch.coupling_value)
);

// ----- verif/tb_windowed_distance_weight_accumulator.sv -----
`timescale 1ns / 1ps

module tb_windowed_distance_weight_accumulator;
  import wdwa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;
  localparam logic [POS_W-1:0]  POS_MAX      = '1;
  localparam logic [VAL_W-1:0]  COUP_MAX     = '1;

  typedef struct packed {
    logic [VAL_W-1:0] coupling_value;
    logic             saturated;
  } readout_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] idx;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic               fixed;  // result typed in below, not predicted
    readout_t           want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wdwa_in_if  in_ch();
  wdwa_out_if out_ch();

  windowed_distance_weight_accumulator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // shadow copy of the block's registers and tables
  logic [15:0]       bin_size_r;
  logic [7:0]        flank_r;
  logic [10:0]       frag_r;
  logic [12:0]       bins_used_r;
  logic [POS_W-1:0]  coord_tab    [NUM_BINS];
  bit                coord_set    [NUM_BINS];
  logic [WGT_W-1:0]  weight_tab   [MAX_FRAGMENT];
  bit                weight_set   [MAX_FRAGMENT];
  logic [VAL_W-1:0]  coupling_tab [NUM_BINS];

  readout_t pending_readouts[$];
  int       errors, n_items, n_results, n_sat, n_sites, n_phases;
  bit       quiet;

  stim_row_t directed_rows[] = '{
    '{MODE_RD_COUP,   12'd0,    28'd0,    32'd0,          1'b1, 33'd0},
    '{MODE_RD_COUP,   12'd4095, 28'd0,    32'd0,          1'b1, 33'd0},
    '{MODE_SPARE_5,   12'd4095, POS_MAX,  COUP_MAX,       1'b1, 33'd0},
    '{MODE_SPARE_6,   12'd1,    28'd7,    32'd9,          1'b1, 33'd0},
    '{MODE_SPARE_7,   12'd0,    POS_MAX,  COUP_MAX,       1'b1, 33'd0},
    '{MODE_WR_WEIGHT, 12'd4095, 28'd0,    COUP_MAX,       1'b1, 33'd0},
    '{MODE_WR_COORD,  12'd5,    28'd0,    32'd0,          1'b1, 33'd0},
    '{MODE_WR_COUP,   12'd5,    28'd0,    COUP_MAX,       1'b1, 33'd0},
    '{MODE_ADD_SITE,  12'd0,    28'd0,    32'd0,          1'b0, 33'd0},
    '{MODE_RD_COUP,   12'd5,    28'd0,    32'd0,          1'b1, {COUP_MAX, 1'b0}},
    '{MODE_WR_COORD,  12'd4095, POS_MAX,  32'd0,          1'b1, 33'd0},
    '{MODE_ADD_SITE,  12'd0,    POS_MAX,  32'd0,          1'b0, 33'd0},
    '{MODE_RD_COUP,   12'd4095, 28'd0,    32'd0,          1'b0, 33'd0},
    '{MODE_WR_WEIGHT, 12'd1023, 28'd0,    32'h5a5a8001,   1'b1, 33'd0},
    '{MODE_WR_COORD,  12'd20,   28'd1699, 32'd0,          1'b1, 33'd0},
    '{MODE_WR_COORD,  12'd21,   28'd1700, 32'd0,          1'b1, 33'd0},
    '{MODE_ADD_SITE,  12'd0,    28'd1000, 32'd0,          1'b0, 33'd0},
    '{MODE_RD_COUP,   12'd20,   28'd0,    32'd0,          1'b0, 33'd0},
    '{MODE_RD_COUP,   12'd21,   28'd0,    32'd0,          1'b0, 33'd0},
    '{MODE_WR_COUP,   12'd4095, 28'd0,    32'd0,          1'b1, 33'd0},
    '{MODE_ADD_SITE,  12'd0,    28'd49,   32'd0,          1'b0, 33'd0},
    '{MODE_RD_COUP,   12'd0,    28'd0,    32'd0,          1'b0, 33'd0}
  };

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint unsigned eff_bins();
    return (bins_used_r > NUM_BINS) ? NUM_BINS : bins_used_r;
  endfunction

  function automatic longint unsigned eff_bin_size();
    return (bin_size_r == 0) ? 1 : bin_size_r;
  endfunction

  function automatic longint unsigned eff_frag();
    return (frag_r > MAX_FRAGMENT) ? MAX_FRAGMENT : frag_r;
  endfunction

  // visited bins are lo .. hi-1
  function automatic void site_window(input logic [POS_W-1:0] site,
                                      output longint lo, output longint hi);
    longint unsigned b, lim;
    b   = site / eff_bin_size();
    lim = eff_bins();
    if (lim == 0) begin
      lo = 0;
      hi = 0;
      return;
    end
    lo = (b > flank_r + 1) ? b - flank_r : 1;
    if (lo > lim) lo = lim;
    hi = b + flank_r + 1;
    if (hi > lim) hi = lim;
    lo = lo - 1;
  endfunction

  function automatic readout_t apply_transaction(input logic [MODE_W-1:0] mode,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    readout_t          r;
    longint            lo, hi;
    longint unsigned   d, sum;
    r = '0;
    case (mode)
      MODE_WR_COORD: begin
        coord_tab[idx] = pos;
        coord_set[idx] = 1'b1;
      end
      MODE_WR_WEIGHT: begin
        if (idx < MAX_FRAGMENT) begin
          weight_tab[idx] = val[WGT_W-1:0];
          weight_set[idx] = 1'b1;
        end
      end
      MODE_WR_COUP:   coupling_tab[idx] = val;
      MODE_ADD_SITE: begin
        site_window(pos, lo, hi);
        for (longint k = lo; k < hi; k++) begin
          d = (coord_tab[k] >= pos) ? coord_tab[k] - pos : pos - coord_tab[k];
          if (d < eff_frag()) begin
            sum = coupling_tab[k];
            sum += weight_tab[d];
            if (sum > COUP_MAX) begin
              sum = COUP_MAX;
              r.saturated = 1'b1;
            end
            coupling_tab[k] = sum[31:0];
          end
        end
      end
      MODE_RD_COUP: r.coupling_value = coupling_tab[idx];
      default: ;
    endcase
    return r;
  endfunction

  // caller sits just after a rising edge; valid is left high on return
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                           input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val,
                           input bit fixed, input readout_t want);
    int       gap;
    readout_t r;
    gap = quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= mode;
    in_ch.index    <= idx;
    in_ch.position <= pos;
    in_ch.value    <= val;
    // ready seen mid-cycle means the transaction goes at the next rising edge
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
    r = apply_transaction(mode, idx, pos, val);
    pending_readouts.push_back(fixed ? want : r);
    n_items++;
  endtask

  // loads any missing bin coordinate in the window first, mostly near the site,
  // then any weight that the site will read
  task automatic send_site(input logic [POS_W-1:0] site);
    longint          lo, hi;
    longint unsigned span;
    longint          p;
    longint unsigned d;
    site_window(site, lo, hi);
    span = eff_frag() + 50;
    for (longint k = lo; k < hi; k++) begin
      if (!coord_set[k]) begin
        if ($urandom_range(0, 7) == 0) p = $urandom() & POS_MAX;
        else begin
          p = longint'(site) + longint'($urandom_range(0, 2 * span)) - longint'(span);
          if (p < 0) p = 0;
          if (p > POS_MAX) p = POS_MAX;
        end
        send_item(MODE_WR_COORD, k[INDEX_W-1:0], p[POS_W-1:0], $urandom(), 1'b0, '0);
      end
    end
    for (longint k = lo; k < hi; k++) begin
      d = (coord_tab[k] >= site) ? coord_tab[k] - site : site - coord_tab[k];
      if (d < eff_frag() && !weight_set[d])
        send_item(MODE_WR_WEIGHT, d[INDEX_W-1:0], POS_W'($urandom()), $urandom(),
                  1'b0, '0);
    end
    send_item(MODE_ADD_SITE, INDEX_W'($urandom()), site, $urandom(), 1'b0, '0);
    n_sites++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_cfg(input logic [15:0] bs, input logic [15:0] fl,
                         input logic [15:0] fr, input logic [15:0] bu);
    drain();
    cfg_we <= 1'b1; cfg_index <= CFG_BIN_SIZE;  cfg_data <= bs; @(posedge clk);
    cfg_index <= CFG_FLANK;     cfg_data <= fl; @(posedge clk);
    cfg_index <= CFG_FRAG_LEN;  cfg_data <= fr; @(posedge clk);
    cfg_index <= CFG_BINS_USED; cfg_data <= bu; @(posedge clk);
    cfg_we <= 1'b0;
    bin_size_r  = bs;
    flank_r     = fl[7:0];
    frag_r      = fr[10:0];
    bins_used_r = bu[12:0];
    quiet = (n_phases % 3 == 1);
    n_phases++;
  endtask

  task automatic run_random(input int count, input int site_pct);
    int              sel;
    longint unsigned span;
    logic [POS_W-1:0] site;
    logic [INDEX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      idx = INDEX_W'($urandom());
      if (sel < site_pct) begin
        span = (eff_bins() + 1) * eff_bin_size();
        if (span > POS_MAX) span = POS_MAX;
        if ($urandom_range(0, 9) == 0) site = POS_W'($urandom());
        else site = POS_W'($urandom_range(0, 32'(span)));
        send_site(site);
      end else if (sel < site_pct + 20) begin
        send_item(MODE_RD_COUP, idx, POS_W'($urandom()), $urandom(), 1'b0, '0);
      end else if (sel < site_pct + 32) begin
        send_item(MODE_WR_COORD, idx, POS_W'($urandom()), $urandom(), 1'b0, '0);
      end else if (sel < site_pct + 44) begin
        val = ($urandom_range(0, 2) == 0) ? COUP_MAX - $urandom_range(0, 70000)
                                          : $urandom();
        send_item(MODE_WR_COUP, idx, POS_W'($urandom()), val, 1'b0, '0);
      end else if (sel < site_pct + 54) begin
        send_item(MODE_WR_WEIGHT, idx, POS_W'($urandom()), $urandom(), 1'b0, '0);
      end else begin
        send_item(MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7)), idx,
                  POS_W'($urandom()), $urandom(), 1'b0, '0);
      end
    end
  endtask

  // values seen mid-cycle are the ones the next rising edge takes
  always @(negedge clk) begin
    readout_t w;
    if (out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.saturated) n_sat++;
      if (pending_readouts.size() == 0) begin
        flag_mismatch("unexpected transaction", out_ch.coupling_value, '0);
      end else begin
        w = pending_readouts.pop_front();
        if (out_ch.coupling_value !== w.coupling_value)
          flag_mismatch("coupling_value", out_ch.coupling_value, w.coupling_value);
        if (out_ch.saturated !== w.saturated)
          flag_mismatch("saturated", out_ch.saturated, w.saturated);
      end
    end
  end

  initial begin
    int n;
    out_ch.ready = 1'b0;
    forever begin
      n = quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(negedge clk); while (!out_ch.valid);
      @(posedge clk);
    end
  end

  initial begin
    #20ms;
    $display("timeout waiting for transactions");
    $display("status: fail");
    $finish;
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.mode     = '0;
    in_ch.index    = '0;
    in_ch.position = '0;
    in_ch.value    = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_BIN_SIZE;
    cfg_data  = '0;
    bin_size_r  = 16'd50;
    flank_r     = 8'd10;
    frag_r      = 11'd700;
    bins_used_r = 13'd4096;
    foreach (coupling_tab[i]) coupling_tab[i] = '0;
    foreach (coord_set[i]) coord_set[i] = 1'b0;
    foreach (weight_set[i]) weight_set[i] = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // weight 0 is full scale; other weights are loaded before a site reads them
    send_item(MODE_WR_WEIGHT, '0, '0, 32'h0000ffff, 1'b0, '0);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode == MODE_ADD_SITE) send_site(directed_rows[i].pos);
      else send_item(directed_rows[i].mode, directed_rows[i].idx, directed_rows[i].pos,
                     directed_rows[i].val, directed_rows[i].fixed, directed_rows[i].want);
    end

    set_cfg(16'd1, 16'd0, 16'd1, 16'd1);            run_random(60, 40);
    set_cfg(16'hffff, 16'd255, 16'd1024, 16'd40);   run_random(12, 25);
    set_cfg(16'd0, 16'd3, 16'd0, 16'd0);            run_random(40, 40);
    set_cfg(16'd20, 16'd2, 16'd2047, 16'd8191);     run_random(60, 40);
    set_cfg(16'd1, 16'd1, 16'd1024, 16'd100);       run_random(60, 45);
    set_cfg(16'd50, 16'd10, 16'd700, 16'd4096);     run_random(30, 30);
    repeat (2) begin
      set_cfg(16'($urandom_range(1, 200)), 16'($urandom_range(0, 6)),
              16'($urandom_range(0, 2047)), 16'($urandom_range(0, 8191)));
      run_random(40, 40);
    end
    drain();
    repeat (40) @(posedge clk);

    $display("ran %0d transactions (%0d site adds) over %0d register settings",
             n_items, n_sites, n_phases);
    $display("checked %0d results, %0d of them saturated, %0d mismatches",
             n_results, n_sat, errors);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ----- windowed_distance_weight_accumulator.f -----
sv/wdwa_pkg.sv
sv/wdwa_if.sv
sv/wdwa_ctrl.sv
sv/wdwa_dp.sv
sv/windowed_distance_weight_accumulator.sv
sv/wdwa_checker.sv
verif/tb_windowed_distance_weight_accumulator.sv
